// ===== hdl/text_console_writer_macros.svh =====
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// shared constants and types of the text console writer
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths
	localparam int INDEX_W = 11;
	localparam int VALUE_W = 16;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;

	// character and attribute codes
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

	// operation codes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register index of the color register
	localparam int REG_TEXT_COLOR = 0;

	// one result word
	typedef struct packed {
		logic [VALUE_W-1:0] cell_value;
		logic [ROW_W-1:0]   cursor_row;
		logic [COL_W-1:0]   cursor_col;
		logic               scrolled;
	} res_t;

endpackage

// ===== hdl/text_console_writer.sv =====
// Text console writer: ROWS x COLUMNS store of 16-bit cells (attribute high byte, character low
// byte) with a cursor. A put word writes one character in the color register's attribute (or
// handles a newline), scrolling first when the cursor sits below the last row; a read word returns
// one cell. Words are taken one at a time: the sequencer passes its put or read step and its done
// step, held until the result is taken, before it accepts the next. The store has one write port
// and one registered read port. A put that scrolls first copies each cell one row up, then blanks
// the last row in the color register's attribute. After reset the store is swept to blanks in
// attribute 7, during which no word is accepted; color register writes are taken at any time.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [7:0]         char_code,
	input  logic [INDEX_W-1:0] cell_index,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] cell_value,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [COL_W-1:0]   cursor_col,
	output logic               scrolled
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]         color_q;
	logic               out_valid_q;
	res_t               out_q;
	res_t               res;
	logic               res_valid;
	logic               res_ready;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;
	logic               reg_hit;

	// color register; paddr holds only register 0
	assign pready  = 1'b1;
	assign reg_hit = 32'(paddr >> 2) == REG_TEXT_COLOR;
	assign prdata  = reg_hit ? {24'd0, color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			color_q <= pwdata[7:0];
		end
	end

	// output register between sequencer and result channel
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = out_q.cell_value;
	assign cursor_row = out_q.cursor_row;
	assign cursor_col = out_q.cursor_col;
	assign scrolled   = out_q.scrolled;

	// sequencer
	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.text_color (color_q),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// cell store
	tcw_store #(
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== hdl/tcw_store.sv =====
// cell store: one write port, one registered read port
module tcw_store import tcw_pkg::*; #(
	parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tcw_ctrl.sv =====
// sequencer: clear sweep, scroll copy, fill, put and read of the cell store
`include "text_console_writer_macros.svh"

module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int CELLS = ROWS * COLUMNS,
	localparam int AW = $clog2(CELLS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [7:0]         char_code,
	input  logic [INDEX_W-1:0] cell_index,
	input  logic [7:0]         text_color,
	output logic               res_valid,
	output res_t               res,
	input  logic               res_ready,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  logic [VALUE_W-1:0] mem_rdata
);

	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int XW    = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SCROLL = 7'b0000100,
		S_FILL   = 7'b0001000,
		S_PUT    = 7'b0010000,
		S_READ   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t             st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [7:0]         ch_q;
	logic [INDEX_W-1:0] idx_q;
	logic [VALUE_W-1:0] val_q;
	logic               scr_q;

	logic [XW-1:0]      in_idx_x;
	logic [XW-1:0]      idx_x;
	logic               idx_ok;
	logic [CNT_W-1:0]   put_addr;
	logic [CNT_W-1:0]   copy_addr;
	logic               is_newline;

	// address arithmetic
	assign in_idx_x   = XW'(cell_index);
	assign idx_x      = XW'(idx_q);
	assign idx_ok     = idx_x < XW'(CELLS);
	assign put_addr   = CNT_W'(row_q) * CNT_W'(COLUMNS) + CNT_W'(col_q);
	assign copy_addr  = cnt_q - CNT_W'(COLUMNS + 1);
	assign is_newline = ch_q == NEWLINE_CODE;

	// handshake and result
	assign in_ready        = st_q == S_IDLE;
	assign res_valid       = st_q == S_DONE;
	assign res.cell_value  = val_q;
	assign res.cursor_row  = ROW_W'(row_q);
	assign res.cursor_col  = COL_W'(col_q);
	assign res.scrolled    = scr_q;

	// store port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = {RESET_COLOR, BLANK_CODE};
		mem_raddr = in_idx_x[AW-1:0];
		case (st_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCROLL: begin
				// read at the counter, write the word read in the previous cycle one row up
				mem_raddr = cnt_q[AW-1:0];
				mem_we    = cnt_q > CNT_W'(COLUMNS);
				mem_waddr = copy_addr[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = {text_color, BLANK_CODE};
			end
			S_PUT: begin
				mem_we    = !is_newline;
				mem_waddr = put_addr[AW-1:0];
				mem_wdata = {text_color, ch_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLEAR;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			scr_q <= 1'b0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						cnt_q <= '0;
						st_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						scr_q <= 1'b0;
						if (op == OP_READ) begin
							st_q <= S_READ;
						end else if (row_q == RW'(ROWS)) begin
							cnt_q <= CNT_W'(COLUMNS);
							st_q  <= S_SCROLL;
						end else begin
							st_q <= S_PUT;
						end
					end
				end
				S_SCROLL: begin
					if (cnt_q == CNT_W'(CELLS)) begin
						cnt_q <= CNT_W'(CELLS - COLUMNS);
						st_q  <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						row_q <= RW'(ROWS - 1);
						scr_q <= 1'b1;
						st_q  <= S_PUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PUT: begin
					if (is_newline || col_q == CW'(COLUMNS - 1)) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					st_q <= S_DONE;
				end
				S_READ: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture and result value
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			ch_q  <= char_code;
			idx_q <= cell_index;
		end
		if (st_q == S_READ) begin
			val_q <= idx_ok ? mem_rdata : '0;
		end
		if (st_q == S_PUT) begin
			val_q <= is_newline ? '0 : {text_color, ch_q};
		end
	end

	// checks
	`TCW_ASSERT_IMPL(a_row_range, 1'b1, row_q <= RW'(ROWS), "cursor row beyond pending")
	`TCW_ASSERT_IMPL(a_col_range, 1'b1, col_q <= CW'(COLUMNS - 1), "cursor column out of row")
	`TCW_ASSERT_IMPL(a_copy_dst, (st_q == S_SCROLL) && mem_we, mem_waddr < AW'(CELLS - COLUMNS), "scroll copy hit last row")
	`TCW_ASSERT_IMPL(a_scroll_row, (st_q == S_DONE) && scr_q, row_q >= RW'(ROWS - 1), "scrolled word with cursor above last row")
	`TCW_ASSERT_NEXT(a_fill_next, st_q == S_FILL, (st_q == S_FILL) || (st_q == S_PUT), "fill left to wrong step")

endmodule

// ===== tb/text_console_writer_test.sv =====
// self-checking testbench for the text console writer: directed table, then random phases
module text_console_writer_test import tcw_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = ROWS_DEF * COLUMNS_DEF;

	// one directed stimulus row; want is used only where typed is set
	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic [INDEX_W-1:0] idx;
		logic [7:0] reps;
		logic       typed;
		res_t       want;
	} dir_row_t;

	localparam int DIR_N = 19;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		// fresh screen is blank in the reset attribute
		'{OP_READ, 8'h00, 11'd0,    8'd1,  1'b1, '{{RESET_COLOR, BLANK_CODE}, 5'd0, 7'd0, 1'b0}},
		'{OP_READ, 8'hff, 11'd1999, 8'd1,  1'b1, '{{RESET_COLOR, BLANK_CODE}, 5'd0, 7'd0, 1'b0}},
		// reads past the screen give zero
		'{OP_READ, 8'h00, 11'd2000, 8'd1,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
		'{OP_READ, 8'h00, 11'd2047, 8'd1,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
		// character extremes
		'{OP_PUT,  8'h00, 11'd0,    8'd1,  1'b1, '{16'h0700, 5'd0, 7'd1, 1'b0}},
		'{OP_PUT,  8'hff, 11'h7ff,  8'd1,  1'b1, '{16'h07ff, 5'd0, 7'd2, 1'b0}},
		'{OP_READ, 8'h00, 11'd1,    8'd1,  1'b1, '{16'h07ff, 5'd0, 7'd2, 1'b0}},
		'{OP_PUT,  NEWLINE_CODE, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
		// fill a row, then wrap to the next one
		'{OP_PUT,  8'h41, 11'd0,    8'd79, 1'b0, '0},
		'{OP_PUT,  8'h42, 11'd0,    8'd1,  1'b1, '{16'h0742, 5'd2, 7'd0, 1'b0}},
		// walk down to the last row and past it
		'{OP_PUT,  NEWLINE_CODE, 11'd0, 8'd22, 1'b0, '0},
		'{OP_PUT,  NEWLINE_CODE, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd25, 7'd0, 1'b0}},
		// put with scroll pending moves the screen up
		'{OP_PUT,  8'h43, 11'd0,    8'd1,  1'b1, '{16'h0743, 5'd24, 7'd1, 1'b1}},
		'{OP_READ, 8'h00, 11'd1920, 8'd1,  1'b1, '{16'h0743, 5'd24, 7'd1, 1'b0}},
		'{OP_READ, 8'h00, 11'd79,   8'd1,  1'b1, '{16'h0742, 5'd24, 7'd1, 1'b0}},
		// newline on the last row, then newline that scrolls
		'{OP_PUT,  NEWLINE_CODE, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd25, 7'd0, 1'b0}},
		'{OP_PUT,  NEWLINE_CODE, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd25, 7'd0, 1'b1}},
		'{OP_READ, 8'h00, 11'd1999, 8'd1,  1'b1, '{{RESET_COLOR, BLANK_CODE}, 5'd25, 7'd0, 1'b0}},
		'{OP_READ, 8'h00, 11'd0,    8'd1,  1'b0, '0}
	};

	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 240;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [1:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [7:0]         char_code;
	logic [INDEX_W-1:0] cell_index;
	logic               out_valid;
	logic               out_ready;
	logic [VALUE_W-1:0] cell_value;
	logic [ROW_W-1:0]   cursor_row;
	logic [COL_W-1:0]   cursor_col;
	logic               scrolled;

	// shadow of the screen, cursor and color
	logic [15:0] screen [CELLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  color;

	res_t echo_q [$];
	int   mismatches;
	int   idle_pct;

	text_console_writer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_value (cell_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// apply one word to the shadow screen and return the word the block should send back
	function automatic res_t console_apply(input logic o, input logic [7:0] ch,
			input logic [INDEX_W-1:0] idx);
		res_t r;
		int i;
		int c;
		logic [15:0] cell_word;
		r = '0;
		if (o == OP_READ) begin
			if (int'(idx) < CELLS)
				r.cell_value = screen[idx];
		end else begin
			// scroll pending: move rows up, blank the last row
			if (cur_row >= ROWS_DEF) begin
				for (i = 0; i < CELLS - COLUMNS_DEF; i++)
					screen[i] = screen[i + COLUMNS_DEF];
				for (i = CELLS - COLUMNS_DEF; i < CELLS; i++)
					screen[i] = {color, BLANK_CODE};
				cur_row = ROWS_DEF - 1;
				r.scrolled = 1'b1;
			end
			if (ch == NEWLINE_CODE) begin
				cur_col = 0;
				cur_row++;
			end else begin
				c = (cur_col < COLUMNS_DEF) ? cur_col : COLUMNS_DEF - 1;
				cell_word = {color, ch};
				screen[cur_row * COLUMNS_DEF + c] = cell_word;
				r.cell_value = cell_word;
				cur_col = c + 1;
				if (cur_col >= COLUMNS_DEF) begin
					cur_col = 0;
					cur_row++;
				end
			end
		end
		r.cursor_row = cur_row[ROW_W-1:0];
		r.cursor_col = cur_col[COL_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int seen);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, seen);
	endtask

	// send one input word, with an optional gap before it
	task automatic send_word(input logic o, input logic [7:0] ch, input logic [INDEX_W-1:0] idx,
			input logic typed, input res_t want);
		res_t got;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		char_code  <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = console_apply(o, ch, idx);
		echo_q.push_back(typed ? want : got);
	endtask

	// color register write over apb, only while nothing is in flight
	task automatic set_color(input logic [7:0] c);
		in_valid <= 1'b0;
		psel     <= 1'b1;
		penable  <= 1'b0;
		pwrite   <= 1'b1;
		paddr    <= 2'(REG_TEXT_COLOR * 4);
		pwdata   <= {24'd0, c};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		color = c;
	endtask

	task automatic drain_results;
		while (echo_q.size() != 0) @(posedge clk);
	endtask

	// random word mix: puts with occasional newlines, reads near the cursor or anywhere
	task automatic send_random_word;
		int r;
		int spot;
		logic [INDEX_W-1:0] idx;
		logic [7:0] ch;
		r = $urandom_range(0, 99);
		idx = 11'($urandom_range(0, 2047));
		ch = 8'($urandom_range(0, 255));
		if (r < 30) begin
			if (r < 12) begin
				spot = cur_row * COLUMNS_DEF + cur_col - 1;
				if (spot < 0)
					spot = 0;
				idx = 11'(spot);
			end else if (r < 25) begin
				idx = 11'($urandom_range(0, CELLS - 1));
			end
			send_word(OP_READ, ch, idx, 1'b0, '0);
		end else if (r < 40) begin
			send_word(OP_PUT, NEWLINE_CODE, idx, 1'b0, '0);
		end else begin
			send_word(OP_PUT, ch, idx, 1'b0, '0);
		end
	endtask

	// result checker: each word against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (echo_q.size() == 0) begin
				flag_mismatch("unexpected word", 0, int'(cell_value));
			end else begin
				want = echo_q.pop_front();
				if (cell_value !== want.cell_value)
					flag_mismatch("cell_value", int'(want.cell_value), int'(cell_value));
				if (cursor_row !== want.cursor_row)
					flag_mismatch("cursor_row", int'(want.cursor_row), int'(cursor_row));
				if (cursor_col !== want.cursor_col)
					flag_mismatch("cursor_col", int'(want.cursor_col), int'(cursor_col));
				if (scrolled !== want.scrolled)
					flag_mismatch("scrolled", int'(want.scrolled), int'(scrolled));
			end
		end
	end

	// receiver stalls in random bursts
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// main sequence
	initial begin
		logic [7:0] phase_color [PHASES];
		int         phase_idle [PHASES];
		phase_color = '{8'hff, 8'h00, 8'($urandom_range(0, 255)), 8'h0f,
			8'($urandom_range(0, 255)), 8'hf0};
		phase_idle = '{30, 30, 0, 50, 30, 0};
		mismatches = 0;
		idle_pct   = 25;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		op         <= OP_PUT;
		char_code  <= '0;
		cell_index <= '0;
		// shadow state after reset
		color   = RESET_COLOR;
		cur_row = 0;
		cur_col = 0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = {RESET_COLOR, BLANK_CODE};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int k = 0; k < DIR_N; k++) begin
			for (int n = 0; n < int'(DIR_TAB[k].reps); n++)
				send_word(DIR_TAB[k].op, DIR_TAB[k].ch, DIR_TAB[k].idx,
					DIR_TAB[k].typed, DIR_TAB[k].want);
		end

		// random phases, each under its own color
		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			drain_results();
			set_color(phase_color[p]);
			idle_pct = phase_idle[p];
			for (int n = 0; n < PHASE_WORDS; n++)
				send_random_word();
		end

		in_valid <= 1'b0;
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
